[rtl/core/dcm_pkg.sv]
// dcm_pkg: shared types and constants for the dc motor soft ramp pwm block
// no dependencies; used by the interfaces and every module under rtl/core
`timescale 1ns / 1ps

package dcm_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int STEP_W   = 12;
    localparam int PERIOD_W = 24;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 24;

    localparam logic [STEP_W-1:0]   RAMP_STEP_RST = STEP_W'(410);
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = PERIOD_W'(80000);

    typedef enum logic [1:0] {
        ST_INACTIVE  = 2'd0,
        ST_RAMP_UP   = 2'd1,
        ST_ACTIVE    = 2'd2,
        ST_RAMP_DOWN = 2'd3
    } run_state_t;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_START  = 2'd1,
        FN_STOP   = 2'd2,
        FN_EXPIRE = 2'd3
    } func_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_INPUT_MODE  = 2'd0,
        CFG_KEYPAD_DIR  = 2'd1,
        CFG_RAMP_STEP   = 2'd2,
        CFG_PWM_PERIOD  = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] PIN_OFF   = 2'd0;
    localparam logic [1:0] PIN_RIGHT = 2'd1;
    localparam logic [1:0] PIN_LEFT  = 2'd2;

    typedef struct packed {
        logic                input_mode;
        logic                keypad_direction;
        logic [STEP_W-1:0]   ramp_step;
        logic [PERIOD_W-1:0] pwm_period_counts;
    } cfg_t;

    typedef struct packed {
        run_state_t  motor_state;
        logic        direction;
        logic [1:0]  pin_drive;
        logic        phase_high;
        logic        reload_valid;
    } status_t;

endpackage

[rtl/core/dcm_if.sv]
// dcm_if: valid/ready channels for events, results and register writes
// depends on dcm_pkg
`timescale 1ns / 1ps

interface dcm_in_if #(
    parameter int ADC_BITS = dcm_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, func, adc_sample, input ready);
    modport sink   (input valid, func, adc_sample, output ready);
endinterface

interface dcm_out_if #(
    parameter int ADC_BITS = dcm_pkg::ADC_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    motor_state;
    logic [ADC_BITS-1:0]           duty;
    logic                          direction;
    logic [1:0]                    pin_drive;
    logic                          phase_high;
    logic                          reload_valid;
    logic [dcm_pkg::PERIOD_W-1:0]  reload_count;

    modport source (output valid, motor_state, duty, direction, pin_drive, phase_high,
                    reload_valid, reload_count, input ready);
    modport sink   (input valid, motor_state, duty, direction, pin_drive, phase_high,
                    reload_valid, reload_count, output ready);
endinterface

interface dcm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dcm_pkg::CFG_AW-1:0]  addr;
    logic [dcm_pkg::CFG_DW-1:0]  data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/core/dcm_cfg_regs.sv]
// dcm_cfg_regs: configuration register file behind the write channel
// depends on dcm_pkg and dcm_if
`timescale 1ns / 1ps

module dcm_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    dcm_cfg_if.sink       cfg,
    output dcm_pkg::cfg_t regs
);

    dcm_pkg::cfg_t regs_reg;
    dcm_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (dcm_pkg::cfg_idx_t'(cfg.addr))
                dcm_pkg::CFG_INPUT_MODE:
                    regs_next.input_mode = cfg.data[0];
                dcm_pkg::CFG_KEYPAD_DIR:
                    regs_next.keypad_direction = cfg.data[0];
                dcm_pkg::CFG_RAMP_STEP:
                    regs_next.ramp_step = cfg.data[dcm_pkg::STEP_W-1:0];
                dcm_pkg::CFG_PWM_PERIOD:
                    regs_next.pwm_period_counts = cfg.data[dcm_pkg::PERIOD_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.input_mode        <= 1'b0;
            regs_reg.keypad_direction  <= 1'b0;
            regs_reg.ramp_step         <= dcm_pkg::RAMP_STEP_RST;
            regs_reg.pwm_period_counts <= dcm_pkg::PERIOD_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[rtl/core/dcm_ctrl.sv]
// dcm_ctrl: motor state machine, soft ramp and pwm phase toggle per event
// depends on dcm_pkg
`timescale 1ns / 1ps

module dcm_ctrl #(
    parameter int ADC_BITS = dcm_pkg::ADC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           func,
    input  logic [ADC_BITS-1:0]  adc_sample,
    input  dcm_pkg::cfg_t        regs,
    output dcm_pkg::status_t     status,
    output logic [ADC_BITS-1:0]  duty,
    output logic [ADC_BITS-1:0]  len
);

    localparam int LW = ((ADC_BITS > dcm_pkg::STEP_W) ? ADC_BITS : dcm_pkg::STEP_W) + 2;
    localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};
    localparam logic [ADC_BITS-1:0] MID  = ADC_BITS'(1) << (ADC_BITS - 1);
    localparam logic signed [LW-1:0] MID_S  = LW'(MID);
    localparam logic signed [LW+1:0] FULL_W = (LW+2)'(FULL);

    dcm_pkg::run_state_t state_reg, state_next;
    logic [ADC_BITS-1:0] duty_reg, duty_next;
    logic [ADC_BITS-1:0] tgt_reg, tgt_next;
    logic [ADC_BITS-1:0] pos_reg, pos_next;
    logic                pdir_reg, pdir_next;
    logic                phase_reg, phase_next;

    logic [dcm_pkg::STEP_W-1:0] step;
    logic signed [LW-1:0] step_s, duty_s, tgt_s, pos_s, samp_s;
    logic                 rvalid;
    logic                 dir;

    // twice the distance from mid scale on the chosen side, clamped to full scale
    function automatic logic [ADC_BITS-1:0] offset_of(input logic signed [LW-1:0] p,
                                                      input logic left);
        logic signed [LW+1:0] d;
        d = left ? (LW+2)'(MID_S - p) : (LW+2)'(p - MID_S);
        d = d <<< 1;
        if (d < 0)
            offset_of = '0;
        else if (d > FULL_W)
            offset_of = FULL;
        else
            offset_of = d[ADC_BITS-1:0];
    endfunction

    assign step   = (regs.ramp_step == '0) ? dcm_pkg::STEP_W'(1) : regs.ramp_step;
    assign step_s = LW'(step);
    assign duty_s = LW'(duty_reg);
    assign tgt_s  = LW'(tgt_reg);
    assign pos_s  = LW'(pos_reg);
    assign samp_s = LW'(adc_sample);

    always_comb
    begin
        state_next = state_reg;
        duty_next  = duty_reg;
        tgt_next   = tgt_reg;
        pos_next   = pos_reg;
        pdir_next  = pdir_reg;
        phase_next = phase_reg;
        rvalid     = 1'b0;
        len        = '0;

        unique case (dcm_pkg::func_t'(func))
            dcm_pkg::FN_TICK:
            begin
                if (state_reg == dcm_pkg::ST_RAMP_DOWN)
                begin
                    duty_next = (duty_s < step_s) ? '0 : ADC_BITS'(duty_s - step_s);
                    if (duty_next == '0)
                    begin
                        state_next = dcm_pkg::ST_INACTIVE;
                        phase_next = 1'b0;
                        if (regs.input_mode)
                            pos_next = MID;
                    end
                end
                else if (!regs.input_mode)
                begin
                    if (state_reg == dcm_pkg::ST_ACTIVE)
                        duty_next = adc_sample;
                    else if (state_reg == dcm_pkg::ST_RAMP_UP)
                    begin
                        if (duty_s + step_s >= tgt_s)
                        begin
                            duty_next  = tgt_reg;
                            state_next = dcm_pkg::ST_ACTIVE;
                        end
                        else
                            duty_next = ADC_BITS'(duty_s + step_s);
                    end
                end
                else
                begin
                    if (state_reg == dcm_pkg::ST_ACTIVE)
                    begin
                        pdir_next = (samp_s < MID_S);
                        duty_next = offset_of(samp_s, pdir_next);
                    end
                    else if (state_reg == dcm_pkg::ST_RAMP_UP)
                    begin
                        pdir_next = (tgt_s < MID_S);
                        if (!pdir_next)
                        begin
                            if (pos_s + step_s >= tgt_s)
                            begin
                                pos_next   = tgt_reg;
                                state_next = dcm_pkg::ST_ACTIVE;
                            end
                            else
                                pos_next = ADC_BITS'(pos_s + step_s);
                        end
                        else
                        begin
                            if (pos_s - step_s <= tgt_s)
                            begin
                                pos_next   = tgt_reg;
                                state_next = dcm_pkg::ST_ACTIVE;
                            end
                            else
                                pos_next = ADC_BITS'(pos_s - step_s);
                        end
                        duty_next = offset_of(LW'(pos_next), pdir_next);
                    end
                end
            end
            dcm_pkg::FN_START:
            begin
                state_next = dcm_pkg::ST_RAMP_UP;
                tgt_next   = adc_sample;
            end
            dcm_pkg::FN_STOP:
            begin
                if (state_reg == dcm_pkg::ST_ACTIVE)
                    state_next = dcm_pkg::ST_RAMP_DOWN;
            end
            dcm_pkg::FN_EXPIRE:
            begin
                if (state_reg != dcm_pkg::ST_INACTIVE)
                begin
                    phase_next = !phase_reg;
                    len        = phase_reg ? (FULL - duty_reg) : duty_reg;
                    rvalid     = 1'b1;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        dir = regs.input_mode ? pdir_next : regs.keypad_direction;

        status.motor_state  = state_next;
        status.direction    = dir;
        status.pin_drive    = phase_next ? (dir ? dcm_pkg::PIN_LEFT : dcm_pkg::PIN_RIGHT)
                                         : dcm_pkg::PIN_OFF;
        status.phase_high   = phase_next;
        status.reload_valid = rvalid;
        duty                = duty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcm_pkg::ST_INACTIVE;
            duty_reg  <= '0;
            tgt_reg   <= '0;
            pos_reg   <= MID;
            pdir_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            duty_reg  <= duty_next;
            tgt_reg   <= tgt_next;
            pos_reg   <= pos_next;
            pdir_reg  <= pdir_next;
            phase_reg <= phase_next;
        end
    end

    // leaving the run only happens through a finished ramp down
    a_inactive_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcm_pkg::ST_INACTIVE) |-> (duty_reg == '0 && !phase_reg))
        else $error("inactive motor with duty or high phase");

endmodule

[rtl/core/dcm_reload.sv]
// dcm_reload: result pipeline, reload = floor(len * period / full scale) - 1
// depends on dcm_pkg; division by 2^n-1 is done by folding the high digit back in
`timescale 1ns / 1ps

module dcm_reload #(
    parameter int ADC_BITS = dcm_pkg::ADC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  dcm_pkg::status_t              st_in,
    input  logic [ADC_BITS-1:0]           duty_in,
    input  logic [ADC_BITS-1:0]           len_in,
    input  logic [dcm_pkg::PERIOD_W-1:0]  period,
    output logic                          out_valid,
    output dcm_pkg::status_t              st_out,
    output logic [ADC_BITS-1:0]           duty_out,
    output logic [dcm_pkg::PERIOD_W-1:0]  count_out
);

    localparam int PW    = ADC_BITS + dcm_pkg::PERIOD_W;
    localparam int FOLDS = (dcm_pkg::PERIOD_W + ADC_BITS) / (ADC_BITS - 1) + 2;
    localparam logic [PW-1:0]       FULL_P = PW'({ADC_BITS{1'b1}});
    localparam logic [ADC_BITS:0]   FULL_Y = {1'b0, {ADC_BITS{1'b1}}};

    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    dcm_pkg::status_t             st1_reg, st2_reg, st3_reg, st4_reg;
    logic [ADC_BITS-1:0]          duty1_reg, duty2_reg, duty3_reg, duty4_reg;
    logic [ADC_BITS-1:0]          len1_reg;
    logic [PW-1:0]                prod2_reg, prod2_next;
    logic [dcm_pkg::PERIOD_W-1:0] q3_reg, q3_next;
    logic [ADC_BITS:0]            y3_reg, y3_next;
    logic [dcm_pkg::PERIOD_W-1:0] cnt4_reg, cnt4_next;
    logic [dcm_pkg::PERIOD_W:0]   qc;

    assign prod2_next = PW'(len1_reg) * PW'(period);

    // x = a*2^n + b = a*(2^n-1) + (a+b): quotient gains a, remainder folds to a+b
    always_comb
    begin
        logic [PW-1:0] q;
        logic [PW-1:0] y;
        q = '0;
        y = prod2_reg;
        for (int i = 0; i < FOLDS; i++)
        begin
            q = q + (y >> ADC_BITS);
            y = (y >> ADC_BITS) + (y & FULL_P);
        end
        q3_next = q[dcm_pkg::PERIOD_W-1:0];
        y3_next = y[ADC_BITS:0];
    end

    always_comb
    begin
        qc = {1'b0, q3_reg} + ((y3_reg >= FULL_Y) ? (dcm_pkg::PERIOD_W+1)'(1) : '0);
        if (!st3_reg.reload_valid || qc == '0)
            cnt4_next = '0;
        else
            cnt4_next = dcm_pkg::PERIOD_W'(qc - (dcm_pkg::PERIOD_W+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_reg   <= st_in;
            duty1_reg <= duty_in;
            len1_reg  <= len_in;
            st2_reg   <= st1_reg;
            duty2_reg <= duty1_reg;
            prod2_reg <= prod2_next;
            st3_reg   <= st2_reg;
            duty3_reg <= duty2_reg;
            q3_reg    <= q3_next;
            y3_reg    <= y3_next;
            st4_reg   <= st3_reg;
            duty4_reg <= duty3_reg;
            cnt4_reg  <= cnt4_next;
        end
    end

    assign out_valid = v4_reg;
    assign st_out    = st4_reg;
    assign duty_out  = duty4_reg;
    assign count_out = cnt4_reg;

endmodule

[rtl/core/dc_motor_soft_ramp_pwm.sv]
// DC motor drive with soft start/stop ramp and pwm phase reload. Takes one event
// beat per clock (ramp tick, start, stop, phase expiry) and gives one result beat
// for each, in order; the result beat reaches res through four register stages
// set by the reload multiply and the divide-by-full-scale fold pipeline. The whole
// pipeline holds while the result beat is not taken. The user must write registers
// over the cfg channel only while no event is in flight; the block does not
// enforce it itself.
// depends on dcm_pkg, dcm_if, dcm_cfg_regs, dcm_ctrl, dcm_reload
`timescale 1ns / 1ps

module dc_motor_soft_ramp_pwm #(
    parameter int ADC_BITS = dcm_pkg::ADC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dcm_in_if.sink     cmd,
    dcm_out_if.source  res,
    dcm_cfg_if.sink    cfg
);

    dcm_pkg::cfg_t                regs;
    dcm_pkg::status_t             st_c, st_o;
    logic [ADC_BITS-1:0]          duty_c, len_c, duty_o;
    logic [dcm_pkg::PERIOD_W-1:0] count_o;
    logic                         out_valid;
    logic                         advance;
    logic                         accept;

    assign advance   = !out_valid || res.ready;
    assign cmd.ready = advance;
    assign accept    = cmd.valid && advance;

    dcm_cfg_regs u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    dcm_ctrl #(.ADC_BITS(ADC_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (cmd.func),
        .adc_sample(cmd.adc_sample),
        .regs      (regs),
        .status    (st_c),
        .duty      (duty_c),
        .len       (len_c)
    );

    dcm_reload #(.ADC_BITS(ADC_BITS)) u_reload (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (accept),
        .st_in    (st_c),
        .duty_in  (duty_c),
        .len_in   (len_c),
        .period   (regs.pwm_period_counts),
        .out_valid(out_valid),
        .st_out   (st_o),
        .duty_out (duty_o),
        .count_out(count_o)
    );

    assign res.valid        = out_valid;
    assign res.motor_state  = st_o.motor_state;
    assign res.duty         = duty_o;
    assign res.direction    = st_o.direction;
    assign res.pin_drive    = st_o.pin_drive;
    assign res.phase_high   = st_o.phase_high;
    assign res.reload_valid = st_o.reload_valid;
    assign res.reload_count = count_o;

    a_reload_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && st_o.reload_valid) |-> (st_o.motor_state != dcm_pkg::ST_INACTIVE))
        else $error("reload reported while motor inactive");

    a_pins_follow_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (st_o.phase_high == (st_o.pin_drive != dcm_pkg::PIN_OFF)))
        else $error("pin drive disagrees with phase");

    a_no_reload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !st_o.reload_valid) |-> (count_o == '0))
        else $error("reload count without reload");

endmodule

[bench/dcm_result_check.sv]
// dcm_result_check: watches the event, result and register channels of the motor drive,
// predicts every result beat from its own copy of motor state and registers, and compares
// depends on dcm_pkg and the channel interfaces in dcm_if
`timescale 1ns / 1ps

module dcm_result_check
    import dcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dcm_in_if    cmd,
    dcm_out_if   res,
    dcm_cfg_if   cfg,
    output int   fail_count,
    output int   pending_results
);

    localparam int FULL = (1 << ADC_BITS_DEF) - 1;
    localparam int MID  = 1 << (ADC_BITS_DEF - 1);

    typedef struct packed {
        run_state_t          motor_state;
        logic [11:0]         duty;
        logic                direction;
        logic [1:0]          pin_drive;
        logic                phase_high;
        logic                reload_valid;
        logic [PERIOD_W-1:0] reload_count;
    } motor_status_t;

    // registers as last written
    logic   mode_pot;
    logic   keypad_left;
    int     step_cfg;
    longint period_cnt;

    // motor state
    run_state_t run_st;
    int         duty_lvl;
    int         target_lvl;
    int         ramp_pos;
    logic       pot_left;
    logic       phase_hi;

    motor_status_t motor_status_q[$];
    motor_status_t want;

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] exp_val);
        // keep the log short when everything goes wrong
        if (fail_count < 50)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_val, $realtime);
        fail_count++;
    endtask

    function automatic int side_offset(input int pos, input logic left);
        int d;
        d = left ? (MID - pos) * 2 : (pos - MID) * 2;
        if (d < 0)
            return 0;
        if (d > FULL)
            return FULL;
        return d;
    endfunction

    function automatic logic [PERIOD_W-1:0] reload_len(input int len);
        longint span;
        span = (longint'(len) * period_cnt) / FULL;
        return span > 0 ? PERIOD_W'(span - 1) : '0;
    endfunction

    function automatic motor_status_t apply_event(input func_t fn, input int sample);
        int            stp;
        logic          dir;
        motor_status_t r;
        stp = (step_cfg == 0) ? 1 : step_cfg;
        r.reload_valid = 1'b0;
        r.reload_count = '0;
        case (fn)
            FN_TICK:
            begin
                if (run_st == ST_RAMP_DOWN) begin
                    duty_lvl = (duty_lvl < stp) ? 0 : duty_lvl - stp;
                    if (duty_lvl == 0) begin
                        run_st   = ST_INACTIVE;
                        phase_hi = 1'b0;
                        if (mode_pot)
                            ramp_pos = MID;
                    end
                end else if (!mode_pot) begin
                    if (run_st == ST_ACTIVE) begin
                        duty_lvl = sample;
                    end else if (run_st == ST_RAMP_UP) begin
                        if (duty_lvl + stp >= target_lvl) begin
                            duty_lvl = target_lvl;
                            run_st   = ST_ACTIVE;
                        end else begin
                            duty_lvl = duty_lvl + stp;
                        end
                    end
                end else if (run_st == ST_ACTIVE) begin
                    pot_left = (sample < MID);
                    duty_lvl = side_offset(sample, pot_left);
                end else if (run_st == ST_RAMP_UP) begin
                    pot_left = (target_lvl < MID);
                    // ramp ends on the tick that would reach or pass the target
                    if (!pot_left) begin
                        if (ramp_pos + stp >= target_lvl) begin
                            ramp_pos = target_lvl;
                            run_st   = ST_ACTIVE;
                        end else begin
                            ramp_pos = ramp_pos + stp;
                        end
                    end else begin
                        if (ramp_pos - stp <= target_lvl) begin
                            ramp_pos = target_lvl;
                            run_st   = ST_ACTIVE;
                        end else begin
                            ramp_pos = ramp_pos - stp;
                        end
                    end
                    duty_lvl = side_offset(ramp_pos, pot_left);
                end
            end
            FN_START:
            begin
                run_st     = ST_RAMP_UP;
                target_lvl = sample;
            end
            FN_STOP:
            begin
                if (run_st == ST_ACTIVE)
                    run_st = ST_RAMP_DOWN;
            end
            default:
            begin
                if (run_st != ST_INACTIVE) begin
                    if (phase_hi) begin
                        phase_hi       = 1'b0;
                        r.reload_count = reload_len(FULL - duty_lvl);
                    end else begin
                        phase_hi       = 1'b1;
                        r.reload_count = reload_len(duty_lvl);
                    end
                    r.reload_valid = 1'b1;
                end
            end
        endcase
        dir           = mode_pot ? pot_left : keypad_left;
        r.motor_state = run_st;
        r.duty        = duty_lvl[11:0];
        r.direction   = dir;
        r.pin_drive   = phase_hi ? (dir ? PIN_LEFT : PIN_RIGHT) : PIN_OFF;
        r.phase_high  = phase_hi;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_pot        = 1'b0;
            keypad_left     = 1'b0;
            step_cfg        = int'(RAMP_STEP_RST);
            period_cnt      = longint'(PERIOD_RST);
            run_st          = ST_INACTIVE;
            duty_lvl        = 0;
            target_lvl      = 0;
            ramp_pos        = MID;
            pot_left        = 1'b0;
            phase_hi        = 1'b0;
            fail_count      = 0;
            pending_results = 0;
            motor_status_q.delete();
        end else begin
            if (res.valid && res.ready) begin
                if (motor_status_q.size() == 0) begin
                    report("result beat with nothing expected", '0, '0);
                end else begin
                    want = motor_status_q.pop_front();
                    if (res.motor_state !== want.motor_state)
                        report("motor_state", 24'(res.motor_state), 24'(want.motor_state));
                    if (res.duty !== want.duty)
                        report("duty", 24'(res.duty), 24'(want.duty));
                    if (res.direction !== want.direction)
                        report("direction", 24'(res.direction), 24'(want.direction));
                    if (res.pin_drive !== want.pin_drive)
                        report("pin_drive", 24'(res.pin_drive), 24'(want.pin_drive));
                    if (res.phase_high !== want.phase_high)
                        report("phase_high", 24'(res.phase_high), 24'(want.phase_high));
                    if (res.reload_valid !== want.reload_valid)
                        report("reload_valid", 24'(res.reload_valid),
                               24'(want.reload_valid));
                    if (res.reload_count !== want.reload_count)
                        report("reload_count", res.reload_count, want.reload_count);
                end
            end
            if (cmd.valid && cmd.ready)
                motor_status_q.push_back(apply_event(func_t'(cmd.func), int'(cmd.adc_sample)));
            if (cfg.valid && cfg.ready) begin
                case (cfg_idx_t'(cfg.addr))
                    CFG_INPUT_MODE: mode_pot    = cfg.data[0];
                    CFG_KEYPAD_DIR: keypad_left = cfg.data[0];
                    CFG_RAMP_STEP:  step_cfg    = int'(cfg.data[STEP_W-1:0]);
                    CFG_PWM_PERIOD: period_cnt  = longint'(cfg.data[PERIOD_W-1:0]);
                    default: ;
                endcase
            end
            pending_results = motor_status_q.size();
        end
    end

endmodule

[bench/testbench.sv]
// testbench: drives events and register writes into the motor drive with random stalls
// on both sides and gives the verdict from the failure count of dcm_result_check
// depends on dcm_pkg, dcm_if, dcm_result_check and dc_motor_soft_ramp_pwm
`timescale 1ns / 1ps

module testbench;
    import dcm_pkg::*;

    localparam int MID         = 1 << (ADC_BITS_DEF - 1);
    localparam int PHASE_ITEMS = 65;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int send_idle = 29;
    int recv_idle = 75;
    int events_sent = 0;
    int phase_start;
    int run_len;
    int pick;
    int fail_count;
    int pending_results;
    logic [11:0]         level;
    logic [STEP_W-1:0]   step_val;
    logic [PERIOD_W-1:0] period_val;

    dcm_in_if  cmd_if();
    dcm_out_if res_if();
    dcm_cfg_if cfg_if();

    dc_motor_soft_ramp_pwm dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    dcm_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_if),
        .res             (res_if),
        .cfg             (cfg_if),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // valid stays high from one beat to the next unless an idle cycle is drawn
    task automatic send_event(input func_t fn, input logic [11:0] sample);
        while ($urandom_range(99) < send_idle) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.func       <= fn;
        cmd_if.adc_sample <= sample;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        cmd_if.valid      = 1'b0;
        cmd_if.func       = FN_TICK;
        cmd_if.adc_sample = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.addr       = CFG_INPUT_MODE;
        cfg_if.data       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keypad mode with the reset registers: events while inactive are ignored,
        // stop during ramp up is ignored, ramp reaches the target, both phases
        send_event(FN_EXPIRE, 12'hfff);
        send_event(FN_TICK, 12'h800);
        send_event(FN_STOP, 12'h000);
        send_event(FN_START, 12'd1000);
        send_event(FN_STOP, 12'h555);
        send_event(FN_TICK, 12'haaa);
        send_event(FN_TICK, 12'h555);
        send_event(FN_TICK, 12'hfff);
        send_event(FN_EXPIRE, 12'h000);
        send_event(FN_EXPIRE, 12'h000);
        send_event(FN_TICK, 12'h000);
        send_event(FN_STOP, 12'h000);
        send_event(FN_TICK, 12'h000);
        wait_drained();

        // potentiometer mode: full left, both sides of mid scale, far side ramp
        write_reg(CFG_INPUT_MODE, CFG_DW'(1));
        write_reg(CFG_RAMP_STEP, CFG_DW'(1024));
        send_event(FN_START, 12'h000);
        send_event(FN_TICK, 12'h123);
        send_event(FN_TICK, 12'hedc);
        send_event(FN_EXPIRE, 12'h000);
        send_event(FN_TICK, 12'(MID));
        send_event(FN_TICK, 12'(MID - 1));
        send_event(FN_START, 12'hfff);
        send_event(FN_TICK, 12'h000);
        send_event(FN_EXPIRE, 12'h000);
        send_event(FN_STOP, 12'h000);

        for (int p = 0; p < 8; p++) begin
            send_idle = (p < 3) ? 29 : ((p < 6) ? 75 : 0);
            recv_idle = (p < 3) ? 75 : ((p < 6) ? 29 : 0);
            case (p)
                0: step_val = 12'd4095;
                1: step_val = 12'd0;
                2: step_val = 12'd1;
                3: step_val = RAMP_STEP_RST;
                default: step_val = 12'($urandom_range(1, 4095));
            endcase
            case (p)
                0: period_val = 24'hffffff;
                1: period_val = PERIOD_RST;
                2: period_val = 24'd0;
                3: period_val = 24'd1;
                default: period_val = 24'($urandom);
            endcase
            wait_drained();
            write_reg(CFG_INPUT_MODE, CFG_DW'(p % 2));
            write_reg(CFG_KEYPAD_DIR, CFG_DW'((p / 2) % 2));
            write_reg(CFG_RAMP_STEP, CFG_DW'(step_val));
            write_reg(CFG_PWM_PERIOD, CFG_DW'(period_val));

            phase_start = events_sent;
            while (events_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(4) != 0) begin
                    // start, run for a while, stop, then let it ramp down
                    pick = $urandom_range(9);
                    case (pick)
                        0: level = 12'h000;
                        1: level = 12'hfff;
                        2: level = 12'(MID);
                        3: level = 12'(MID - 1);
                        4: level = 12'($urandom_range(MID - 8, MID + 8));
                        5: level = 12'($urandom_range(0, 8));
                        default: level = 12'($urandom);
                    endcase
                    send_event(FN_START, level);
                    run_len = $urandom_range(1, 12);
                    repeat (run_len)
                        send_event(($urandom_range(9) < 7) ? FN_TICK : FN_EXPIRE, 12'($urandom));
                    send_event(FN_STOP, 12'($urandom));
                    run_len = $urandom_range(0, 12);
                    repeat (run_len)
                        send_event(($urandom_range(9) < 7) ? FN_TICK : FN_EXPIRE, 12'($urandom));
                end else begin
                    run_len = $urandom_range(1, 4);
                    repeat (run_len)
                        send_event(func_t'($urandom_range(3)), 12'($urandom));
                end
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dcm_pkg.sv
rtl/core/dcm_if.sv
rtl/core/dcm_cfg_regs.sv
rtl/core/dcm_ctrl.sv
rtl/core/dcm_reload.sv
rtl/core/dc_motor_soft_ramp_pwm.sv
bench/dcm_result_check.sv
bench/testbench.sv
